>>> src/ecp_pkg.sv
`default_nettype none

package ecp_pkg;

  // Screen width in columns; columns at or beyond it are outside the span.
  localparam int COLUMNS = 64;

  // Field widths.
  localparam int COL_W   = 6;
  localparam int AXIS_W  = 16;
  localparam int LIMIT_W = 9;
  localparam int ROW_W   = 10;
  localparam int IDX_W   = 3;
  localparam int CNT_W   = 5;

  // Serial step counts of each phase.
  localparam int SQR_STEPS  = 16;
  localparam int MUL_STEPS  = 32;
  localparam int DIV_STEPS  = 32;
  localparam int ROOT_STEPS = 16;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_SEMI_AXIS_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_SEMI_AXIS_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_CENTER_X    = 3'd2;
  localparam logic [IDX_W-1:0] REG_CENTER_Y    = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROW_LIMIT   = 3'd4;

  // Register reset values.
  localparam logic [AXIS_W-1:0]  SEMI_AXIS_X_RESET = 16'd2560;
  localparam logic [AXIS_W-1:0]  SEMI_AXIS_Y_RESET = 16'd2560;
  localparam logic [AXIS_W-1:0]  CENTER_X_RESET    = 16'd5120;
  localparam logic [AXIS_W-1:0]  CENTER_Y_RESET    = 16'd5120;
  localparam logic [LIMIT_W-1:0] ROW_LIMIT_RESET   = 9'd42;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic             lower_half;
  } in_t;

  typedef struct packed {
    logic signed [ROW_W-1:0] row;
    logic                    plot;
    logic                    stopped;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_MUL,
    ST_DIV,
    ST_ROOT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> src/ellipse_column_plotter_unit.sv
`default_nettype none

// Ellipse column plotter.
// A request on the input channel carries a screen column and a half selector
// (upper or lower). For each request exactly one result leaves on the output
// channel: the ellipse row at that column, whether it is plotted, and the stop
// flag of that half. Both channels use valid/ready.
// The root is computed with bit-serial arithmetic: the three squares of the
// semi-axes and the column offset run together, then follow the 32x32
// product, the restoring division and the square root, two bits per cycle.
// A column outside the span goes from idle straight to the done state. The
// next request is taken in the cycle after the result is loaded into the
// output register; until then the unit takes no new request.
// The output register lets a new request be accepted while the previous result
// still waits; if the receiver stalls longer, the finished result is held in
// the last step until the output register frees up.
// Reset loads the register defaults, clears both stop flags and empties the
// output register. Configuration writes are taken at once; the user must
// make them only while idle, as the block itself does not enforce it.
module ellipse_column_plotter_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire ecp_pkg::in_t                 in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output ecp_pkg::out_t                     out_data,
  input  wire logic                         cfg_we,
  input  wire logic [ecp_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [ecp_pkg::AXIS_W-1:0]   cfg_wdata
);

  // Configuration registers.
  logic        [15:0] semi_axis_x_r;
  logic        [15:0] semi_axis_y_r;
  logic signed [15:0] center_x_r;
  logic signed [15:0] center_y_r;
  logic        [8:0]  row_limit_r;

  // Control state.
  ecp_pkg::state_t state_r, state_nxt;
  logic [ecp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0] half_stopped_r, half_stopped_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic        half_r, half_nxt;
  logic        in_span_r, in_span_nxt;
  logic [15:0] d_abs_r, d_abs_nxt;
  logic [31:0] sq_a_r, sq_a_nxt;
  logic [31:0] sq_d_r, sq_d_nxt;
  logic [31:0] sq_b_r, sq_b_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] root_r, root_nxt;
  ecp_pkg::out_t out_r, out_nxt;

  // Handshake decodes.
  logic in_fire;
  logic out_free;
  logic out_load;
  logic last_sqr, last_mul, last_div, last_root;

  // Span check of the incoming column.
  logic signed [16:0] d_in;
  logic        [16:0] d_in_abs;
  logic               span_in;

  // Serial step logic.
  logic [16:0] sqa_sum, sqd_sum, sqb_sum;
  logic [32:0] mul_sum;
  logic [32:0] div_trial;
  logic        div_ge;
  logic [32:0] div_diff;
  logic [18:0] root_trial_rem;
  logic [18:0] root_trial_sub;
  logic        root_ge;

  // Final row.
  logic signed [17:0] yq;
  logic        [17:0] yq_mag;
  logic        [9:0]  row_mag;
  logic signed [9:0]  row_val;
  logic               row_over;

  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign last_sqr  = (cnt_r == ecp_pkg::CNT_W'(ecp_pkg::SQR_STEPS - 1));
  assign last_mul  = (cnt_r == ecp_pkg::CNT_W'(ecp_pkg::MUL_STEPS - 1));
  assign last_div  = (cnt_r == ecp_pkg::CNT_W'(ecp_pkg::DIV_STEPS - 1));
  assign last_root = (cnt_r == ecp_pkg::CNT_W'(ecp_pkg::ROOT_STEPS - 1));

  // Offset of the column from the center, and whether it lies in the span.
  assign d_in     = $signed({1'b0, in_data.column, 8'b0}) - 17'(center_x_r);
  assign d_in_abs = d_in[16] ? 17'(-d_in) : d_in;
  assign span_in  = (32'(in_data.column) < ecp_pkg::COLUMNS) &&
                    (semi_axis_x_r != 16'd0) &&
                    (d_in_abs <= {1'b0, semi_axis_x_r});

  // One multiplier bit per cycle for each of the three squares.
  assign sqa_sum = {1'b0, sq_a_r[31:16]} + (sq_a_r[0] ? {1'b0, semi_axis_x_r} : 17'd0);
  assign sqd_sum = {1'b0, sq_d_r[31:16]} + (sq_d_r[0] ? {1'b0, d_abs_r} : 17'd0);
  assign sqb_sum = {1'b0, sq_b_r[31:16]} + (sq_b_r[0] ? {1'b0, semi_axis_y_r} : 17'd0);

  // One bit per cycle of b*b times (a*a - d*d).
  assign mul_sum = {1'b0, prod_r[63:32]} + (prod_r[0] ? {1'b0, sq_b_r} : 33'd0);

  // One quotient bit per cycle; the partial remainder stays below a*a.
  assign div_trial = {prod_r[63:32], prod_r[31]};
  assign div_ge    = (div_trial >= {1'b0, sq_a_r});
  assign div_diff  = div_trial - {1'b0, sq_a_r};

  // Two radicand bits per cycle for the square root.
  assign root_trial_rem = {rem_r, prod_r[31:30]};
  assign root_trial_sub = {1'b0, root_r, 2'b01};
  assign root_ge        = (root_trial_rem >= root_trial_sub);

  // Row from the center and the root, truncated toward zero.
  assign yq      = half_r ? (18'(center_y_r) - $signed({2'b0, root_r}))
                          : (18'(center_y_r) + $signed({2'b0, root_r}));
  assign yq_mag  = yq[17] ? 18'(-yq) : yq;
  assign row_mag = yq_mag[17:8];
  assign row_val = yq[17] ? 10'(-$signed(row_mag)) : $signed(row_mag);
  assign row_over = ($signed({row_val[9], row_val}) > $signed({2'b0, row_limit_r}));

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ecp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = span_in ? ecp_pkg::ST_SQR : ecp_pkg::ST_DONE;
        end
      end
      ecp_pkg::ST_SQR: begin
        if (last_sqr) begin
          state_nxt = ecp_pkg::ST_MUL;
        end
      end
      ecp_pkg::ST_MUL: begin
        if (last_mul) begin
          state_nxt = ecp_pkg::ST_DIV;
        end
      end
      ecp_pkg::ST_DIV: begin
        if (last_div) begin
          state_nxt = ecp_pkg::ST_ROOT;
        end
      end
      ecp_pkg::ST_ROOT: begin
        if (last_root) begin
          state_nxt = ecp_pkg::ST_DONE;
        end
      end
      ecp_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = ecp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ecp_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ecp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      ecp_pkg::ST_DONE: begin
        out_load = out_free;
      end
      ecp_pkg::ST_SQR, ecp_pkg::ST_MUL, ecp_pkg::ST_DIV, ecp_pkg::ST_ROOT: begin
        in_ready = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    cnt_nxt          = cnt_r;
    half_stopped_nxt = half_stopped_r;
    out_valid_nxt    = out_valid_r;
    half_nxt         = half_r;
    in_span_nxt      = in_span_r;
    d_abs_nxt        = d_abs_r;
    sq_a_nxt         = sq_a_r;
    sq_d_nxt         = sq_d_r;
    sq_b_nxt         = sq_b_r;
    prod_nxt         = prod_r;
    rem_nxt          = rem_r;
    root_nxt         = root_r;
    out_nxt          = out_r;

    // The receiver takes the current result.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ecp_pkg::ST_IDLE: begin
        if (in_fire) begin
          cnt_nxt     = '0;
          half_nxt    = in_data.lower_half;
          in_span_nxt = span_in;
          d_abs_nxt   = d_in_abs[15:0];
          sq_a_nxt    = {16'b0, semi_axis_x_r};
          sq_d_nxt    = {16'b0, d_in_abs[15:0]};
          sq_b_nxt    = {16'b0, semi_axis_y_r};
          // Column zero restarts its half.
          if (in_data.column == '0) begin
            half_stopped_nxt[in_data.lower_half] = 1'b0;
          end
        end
      end
      ecp_pkg::ST_SQR: begin
        cnt_nxt  = cnt_r + 1'b1;
        sq_a_nxt = {sqa_sum, sq_a_r[15:1]};
        sq_d_nxt = {sqd_sum, sq_d_r[15:1]};
        sq_b_nxt = {sqb_sum, sq_b_r[15:1]};
        if (last_sqr) begin
          cnt_nxt  = '0;
          // Multiplier operand a*a - d*d, never negative inside the span.
          prod_nxt = {32'b0, {sqa_sum, sq_a_r[15:1]} - {sqd_sum, sq_d_r[15:1]}};
        end
      end
      ecp_pkg::ST_MUL: begin
        cnt_nxt  = last_mul ? '0 : cnt_r + 1'b1;
        prod_nxt = {mul_sum, prod_r[31:1]};
      end
      ecp_pkg::ST_DIV: begin
        cnt_nxt  = last_div ? '0 : cnt_r + 1'b1;
        prod_nxt = {(div_ge ? div_diff[31:0] : div_trial[31:0]), prod_r[30:0], div_ge};
        if (last_div) begin
          rem_nxt  = '0;
          root_nxt = '0;
        end
      end
      ecp_pkg::ST_ROOT: begin
        cnt_nxt  = last_root ? '0 : cnt_r + 1'b1;
        rem_nxt  = root_ge ? 17'(root_trial_rem - root_trial_sub) : root_trial_rem[16:0];
        root_nxt = {root_r[14:0], root_ge};
        prod_nxt = {prod_r[63:32], prod_r[29:0], 2'b00};
      end
      ecp_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_nxt.row     = '0;
          out_nxt.plot    = 1'b0;
          out_nxt.stopped = half_stopped_r[half_r];
          if (in_span_r) begin
            out_nxt.row = row_val;
            if (!half_stopped_r[half_r]) begin
              if (row_over) begin
                half_stopped_nxt[half_r] = 1'b1;
                out_nxt.stopped          = 1'b1;
              end else begin
                out_nxt.plot = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ecp_pkg::ST_IDLE;
      cnt_r          <= '0;
      half_stopped_r <= '0;
      out_valid_r    <= 1'b0;
      semi_axis_x_r  <= ecp_pkg::SEMI_AXIS_X_RESET;
      semi_axis_y_r  <= ecp_pkg::SEMI_AXIS_Y_RESET;
      center_x_r     <= $signed(ecp_pkg::CENTER_X_RESET);
      center_y_r     <= $signed(ecp_pkg::CENTER_Y_RESET);
      row_limit_r    <= ecp_pkg::ROW_LIMIT_RESET;
    end else begin
      state_r        <= state_nxt;
      cnt_r          <= cnt_nxt;
      half_stopped_r <= half_stopped_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ecp_pkg::REG_SEMI_AXIS_X: semi_axis_x_r <= cfg_wdata;
          ecp_pkg::REG_SEMI_AXIS_Y: semi_axis_y_r <= cfg_wdata;
          ecp_pkg::REG_CENTER_X:    center_x_r    <= $signed(cfg_wdata);
          ecp_pkg::REG_CENTER_Y:    center_y_r    <= $signed(cfg_wdata);
          ecp_pkg::REG_ROW_LIMIT:   row_limit_r   <= cfg_wdata[8:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    half_r    <= half_nxt;
    in_span_r <= in_span_nxt;
    d_abs_r   <= d_abs_nxt;
    sq_a_r    <= sq_a_nxt;
    sq_d_r    <= sq_d_nxt;
    sq_b_r    <= sq_b_nxt;
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
